// ----- design/nnrs_pkg.sv -----
package nnrs_pkg;

  // default image store geometry
  localparam int DEF_MAX_SOURCE_WIDTH  = 128;
  localparam int DEF_MAX_SOURCE_HEIGHT = 128;

  // destination sizes above this act as this value
  localparam int MAX_DEST_DIM = 4095;

  // field and register widths
  localparam int SIZE_W  = 8;
  localparam int DIM_W   = 12;
  localparam int COORD_W = 12;
  localparam int PIX_W   = 32;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 2;

  // divider geometry: quotient is always below the source size
  localparam int PROD_W = COORD_W + SIZE_W;
  localparam int QUO_W  = SIZE_W;
  localparam int CNT_W  = $clog2(QUO_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  // item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic capture;    // latch accepted transaction
    logic store_wr;   // write loaded pixel to the store
    logic div_load;   // multiply and seed the divider
    logic div_step;   // one restoring step
    logic div_save;   // keep clamped quotient
    logic sel_y;      // row pass when set, column pass otherwise
    logic rd_en;      // read the store
    logic out_load;   // fill the output register
  } cmd_t;

  typedef struct packed {
    logic kind_req;
    logic load_ok;
    logic req_oor;
    logic out_free;
  } status_t;

endpackage

// ----- design/nnrs_if.sv -----
interface nnrs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [nnrs_pkg::COORD_W-1:0]  coord_x;
  logic [nnrs_pkg::COORD_W-1:0]  coord_y;
  logic [nnrs_pkg::PIX_W-1:0]    pixel_in;

  modport source (output valid, kind, coord_x, coord_y, pixel_in, input ready);
  modport sink   (input valid, kind, coord_x, coord_y, pixel_in, output ready);
endinterface

interface nnrs_out_if;
  logic                        valid;
  logic                        ready;
  logic [nnrs_pkg::PIX_W-1:0]  pixel_out;
  logic                        out_of_range;

  modport source (output valid, pixel_out, out_of_range, input ready);
  modport sink   (input valid, pixel_out, out_of_range, output ready);
endinterface

// ----- design/nnrs_ram.sv -----
module nnrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/nnrs_datapath.sv -----
module nnrs_datapath #(
  parameter int MAX_SOURCE_WIDTH  = nnrs_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = nnrs_pkg::DEF_MAX_SOURCE_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input payload
  input  logic                            kind_i,
  input  logic [nnrs_pkg::COORD_W-1:0]    coord_x_i,
  input  logic [nnrs_pkg::COORD_W-1:0]    coord_y_i,
  input  logic [nnrs_pkg::PIX_W-1:0]      pixel_in_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [nnrs_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                            out_of_range_o,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [nnrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nnrs_pkg::CFG_W-1:0]      cfg_data_i,
  // control
  input  nnrs_pkg::cmd_t                  cmd_i,
  output nnrs_pkg::status_t               st_o
);

  localparam int SZW   = nnrs_pkg::SIZE_W;
  localparam int DMW   = nnrs_pkg::DIM_W;
  localparam int CW    = nnrs_pkg::COORD_W;
  localparam int PXW   = nnrs_pkg::PIX_W;
  localparam int PW    = nnrs_pkg::PROD_W;
  localparam int QW    = nnrs_pkg::QUO_W;
  localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [SZW-1:0] src_w_q, src_h_q;
  logic [DMW-1:0] dst_w_q, dst_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SZW'(1);
      src_h_q <= SZW'(1);
      dst_w_q <= DMW'(1);
      dst_h_q <= DMW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nnrs_pkg::REG_SRC_WIDTH:  src_w_q <= cfg_data_i[SZW-1:0];
        nnrs_pkg::REG_SRC_HEIGHT: src_h_q <= cfg_data_i[SZW-1:0];
        nnrs_pkg::REG_DST_WIDTH:  dst_w_q <= cfg_data_i[DMW-1:0];
        nnrs_pkg::REG_DST_HEIGHT: dst_h_q <= cfg_data_i[DMW-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize acts as the maximum
  logic [SZW-1:0] sw_c, sh_c;
  logic [DMW-1:0] dw_c, dh_c;

  always_comb begin
    sw_c = src_w_q;
    if (src_w_q == '0) begin
      sw_c = SZW'(1);
    end else if (32'(src_w_q) > 32'(MAX_SOURCE_WIDTH)) begin
      sw_c = SZW'(MAX_SOURCE_WIDTH);
    end
    sh_c = src_h_q;
    if (src_h_q == '0) begin
      sh_c = SZW'(1);
    end else if (32'(src_h_q) > 32'(MAX_SOURCE_HEIGHT)) begin
      sh_c = SZW'(MAX_SOURCE_HEIGHT);
    end
    dw_c = dst_w_q;
    if (dst_w_q == '0) begin
      dw_c = DMW'(1);
    end else if (32'(dst_w_q) > 32'(nnrs_pkg::MAX_DEST_DIM)) begin
      dw_c = DMW'(nnrs_pkg::MAX_DEST_DIM);
    end
    dh_c = dst_h_q;
    if (dst_h_q == '0) begin
      dh_c = DMW'(1);
    end else if (32'(dst_h_q) > 32'(nnrs_pkg::MAX_DEST_DIM)) begin
      dh_c = DMW'(nnrs_pkg::MAX_DEST_DIM);
    end
  end

  // captured transaction
  logic           kind_q;
  logic [CW-1:0]  x_q, y_q;
  logic [PXW-1:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      x_q    <= coord_x_i;
      y_q    <= coord_y_i;
      pix_q  <= pixel_in_i;
    end
  end

  logic load_ok, req_oor;
  assign load_ok = ({{(CW-SZW){1'b0}}, sw_c} > x_q) && ({{(CW-SZW){1'b0}}, sh_c} > y_q);
  assign req_oor = (x_q >= CW'(dw_c)) || (y_q >= CW'(dh_c));

  // operand selection for the current pass
  logic [CW-1:0]  op_c;
  logic [SZW-1:0] op_s;
  logic [DMW-1:0] op_d;
  assign op_c = cmd_i.sel_y ? y_q  : x_q;
  assign op_s = cmd_i.sel_y ? sh_c : sw_c;
  assign op_d = cmd_i.sel_y ? dh_c : dw_c;

  // restoring divider; upper product bits are already below the divisor
  logic [PW-1:0]  prod;
  logic [DMW-1:0] rem_q, rem_d;
  logic [QW-1:0]  quo_q, quo_d;
  logic [DMW:0]   trial;
  logic           ge;

  assign prod  = PW'(op_c) * PW'(op_s);
  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = trial >= {1'b0, op_d};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.div_load) begin
      rem_d = prod[PW-1:QW];
      quo_d = prod[QW-1:0];
    end else if (cmd_i.div_step) begin
      rem_d = ge ? DMW'(trial - {1'b0, op_d}) : DMW'(trial);
      quo_d = {quo_q[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  logic [SZW-1:0] lim, pick;
  logic [SZW-1:0] sx_q, sy_q;
  assign lim  = op_s - SZW'(1);
  assign pick = (quo_q > lim) ? lim : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_save) begin
      if (cmd_i.sel_y) begin
        sy_q <= pick;
      end else begin
        sx_q <= pick;
      end
    end
  end

  // pixel store
  logic [AW-1:0]  waddr, raddr;
  logic [PXW-1:0] rdata;
  assign waddr = AW'(32'(y_q) * 32'(MAX_SOURCE_WIDTH) + 32'(x_q));
  assign raddr = AW'(32'(sy_q) * 32'(MAX_SOURCE_WIDTH) + 32'(sx_q));

  nnrs_ram #(
    .WIDTH (PXW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_wr),
    .waddr_i (waddr),
    .wdata_i (pix_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // output register
  logic           out_valid_q;
  logic [PXW-1:0] out_pix_q;
  logic           out_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pix_q <= req_oor ? '0 : rdata;
      out_oor_q <= req_oor;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = out_pix_q;
  assign out_of_range_o = out_oor_q;

  assign st_o.kind_req = (kind_q == nnrs_pkg::KIND_REQUEST);
  assign st_o.load_ok  = load_ok;
  assign st_o.req_oor  = req_oor;
  assign st_o.out_free = !out_valid_q || out_ready_i;

  store_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_wr |-> (32'(x_q) < 32'(MAX_SOURCE_WIDTH)) && (32'(y_q) < 32'(MAX_SOURCE_HEIGHT)))
    else $error("store write outside source area");

  quotient_below_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_save |-> (quo_q < op_s))
    else $error("scaled coordinate not below source size");

endmodule

// ----- design/nnrs_ctrl.sv -----
module nnrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nnrs_pkg::status_t st_i,
  output nnrs_pkg::cmd_t    cmd_o
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] S_DECODE = 3'd1;
  localparam logic [ST_W-1:0] S_MUL    = 3'd2;
  localparam logic [ST_W-1:0] S_DIV    = 3'd3;
  localparam logic [ST_W-1:0] S_SAVE   = 3'd4;
  localparam logic [ST_W-1:0] S_READ   = 3'd5;
  localparam logic [ST_W-1:0] S_RESULT = 3'd6;

  localparam int CNT_W = nnrs_pkg::CNT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(nnrs_pkg::QUO_W - 1);

  logic [ST_W-1:0]  state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pass_y_q, pass_y_d;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pass_y_d = pass_y_q;
    cmd_o    = '0;
    cmd_o.sel_y = pass_y_q;
    in_ready_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        pass_y_d = 1'b0;
        if (!st_i.kind_req) begin
          cmd_o.store_wr = st_i.load_ok;
          state_d = S_IDLE;
        end else if (st_i.req_oor) begin
          state_d = S_RESULT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.div_load = 1'b1;
        cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = S_SAVE;
        end
      end
      S_SAVE: begin
        cmd_o.div_save = 1'b1;
        if (pass_y_q) begin
          state_d = S_READ;
        end else begin
          pass_y_d = 1'b1;
          state_d  = S_MUL;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      pass_y_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pass_y_q <= pass_y_d;
    end
  end

  out_load_needs_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> st_i.out_free)
    else $error("result written over a pending result");

  store_write_only_for_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store_wr |-> !st_i.kind_req && st_i.load_ok)
    else $error("store written by a request");

  divide_takes_full_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> ##9 (state_q == S_SAVE))
    else $error("divider pass ended early or late");

endmodule

// ----- design/nearest_neighbor_rgba_scaler.sv -----
// Nearest-neighbor RGBA8 scaler. A load transaction (kind 0) writes one 32-bit pixel into the
// source store at row*MAX_SOURCE_WIDTH+column and is dropped if it lies outside the configured
// source size; it gives no result. A request transaction (kind 1) maps the destination position
// to src = min(size-1, pos*src_size/dst_size) per axis and returns the stored pixel; its result
// is produced by two passes (column, then row) through one shared 8-step restoring divider
// followed by the registered store read. A request outside the destination size returns zero
// with out_of_range set. One transaction is worked on at a time; a finished result waits in an
// output register, so the next transaction is accepted while it is pending. The store is not
// cleared at reset: request only pixels that were loaded. Write size registers only while idle.
module nearest_neighbor_rgba_scaler #(
  parameter int MAX_SOURCE_WIDTH  = nnrs_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = nnrs_pkg::DEF_MAX_SOURCE_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  nnrs_in_if.sink                         in_i,
  nnrs_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [nnrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nnrs_pkg::CFG_W-1:0]      cfg_data_i
);

  nnrs_pkg::cmd_t    cmd;
  nnrs_pkg::status_t st;

  nnrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  nnrs_datapath #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (in_i.kind),
    .coord_x_i      (in_i.coord_x),
    .coord_y_i      (in_i.coord_y),
    .pixel_in_i     (in_i.pixel_in),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .pixel_out_o    (out_o.pixel_out),
    .out_of_range_o (out_o.out_of_range),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .st_o           (st)
  );

endmodule
